/* sv/jsfrg_pkg.sv */
package jsfrg_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned OP_W = 3;
    localparam int unsigned EXPO_W = 7;
    localparam int unsigned CNT_W = 5;
    localparam int unsigned LZC_W = 6;

    localparam logic [WORD_W-1:0] SEED_A = 32'hf1ea5eed;
    localparam int unsigned SEED_ROUNDS = 20;
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned ROT_B = 27;
    localparam int unsigned ROT_C = 17;
    localparam logic [EXPO_W-1:0] UNIT_EXPO = 7'd126;
    localparam logic [EXPO_W-1:0] EXPO_STEP = 7'd32;
    localparam logic [LZC_W-1:0] EXTRA_UNIT = 6'd8;
    localparam logic [LZC_W-1:0] EXTRA_SIGNED = 6'd7;

    typedef enum logic [OP_W-1:0] {
        OP_RESEED = 3'd0,
        OP_RAW    = 3'd1,
        OP_RANGED = 3'd2,
        OP_UNIT   = 3'd3,
        OP_SIGNED = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        RES_RND,
        RES_REM,
        RES_FLOAT
    } res_sel_t;

    typedef struct packed {
        logic     accept;
        logic     float_signed;
        logic     load_seed;
        logic     round_en;
        logic     rnd_load;
        logic     div_start;
        logic     div_sel_rnd;
        logic     div_step;
        logic     cap_load;
        logic     expo_sub;
        logic     expo_norm;
        logic     push;
        res_sel_t res_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic mod_zero;
        logic cap_ok;
        logic loop_zero;
        logic need_extra;
        logic out_free;
    } dp_status_t;

    function automatic logic [LZC_W-1:0] lzc32(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] x;
        logic [LZC_W-1:0]  n;
        begin
            x = v;
            n = '0;
            if (v == '0)
            begin
                n = 6'd32;
            end
            else
            begin
                if (x[31:16] == '0)
                begin
                    n = n + 6'd16;
                    x = x << 16;
                end
                if (x[31:24] == '0)
                begin
                    n = n + 6'd8;
                    x = x << 8;
                end
                if (x[31:28] == '0)
                begin
                    n = n + 6'd4;
                    x = x << 4;
                end
                if (x[31:30] == '0)
                begin
                    n = n + 6'd2;
                    x = x << 2;
                end
                if (x[31] == 1'b0)
                begin
                    n = n + 6'd1;
                end
            end
            return n;
        end
    endfunction

endpackage

/* sv/jsfrg_datapath.sv */
module jsfrg_datapath
    import jsfrg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    input  logic [WORD_W-1:0] seed_value,
    input  logic [WORD_W-1:0] modulus,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [WORD_W-1:0] out_value,
    output dp_status_t        status
);

    logic [WORD_W-1:0] a_reg, b_reg, c_reg, d_reg;
    logic [WORD_W-1:0] a_next, b_next, c_next, d_next, e_val;
    logic [WORD_W-1:0] rnd_reg;
    logic [WORD_W-1:0] mod_reg;
    logic [WORD_W-1:0] cap_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] dvd_reg;
    logic [EXPO_W-1:0] expo_reg;
    logic              signed_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_value_reg;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   trial_diff;
    logic [LZC_W-1:0]  nz;
    logic [WORD_W-1:0] float_bits;
    logic [WORD_W-1:0] res_value;

    assign e_val  = a_reg - {b_reg[WORD_W-ROT_B-1:0], b_reg[WORD_W-1:WORD_W-ROT_B]};
    assign a_next = b_reg ^ {c_reg[WORD_W-ROT_C-1:0], c_reg[WORD_W-1:WORD_W-ROT_C]};
    assign b_next = c_reg + d_reg;
    assign c_next = d_reg + e_val;
    assign d_next = e_val + a_next;

    assign trial      = {rem_reg, dvd_reg[WORD_W-1]};
    assign trial_diff = trial - {1'b0, mod_reg};

    assign nz = lzc32(rnd_reg);

    assign float_bits = {signed_reg & rnd_reg[23], 1'b0, expo_reg, rnd_reg[22:0]};

    always_comb
    begin
        unique case (cmd.res_sel)
            RES_RND:   res_value = rnd_reg;
            RES_REM:   res_value = rem_reg;
            RES_FLOAT: res_value = float_bits;
            default:   res_value = rnd_reg;
        endcase
    end

    assign status.mod_zero   = (modulus == '0);
    assign status.cap_ok     = (rnd_reg < cap_reg);
    assign status.loop_zero  = (rnd_reg == '0) && (expo_reg > EXPO_STEP);
    assign status.need_extra = nz > (signed_reg ? EXTRA_SIGNED : EXTRA_UNIT);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg         <= SEED_A;
            b_reg         <= '0;
            c_reg         <= '0;
            d_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_seed)
            begin
                a_reg <= SEED_A;
                b_reg <= seed_value;
                c_reg <= seed_value;
                d_reg <= seed_value;
            end
            else if (cmd.round_en)
            begin
                a_reg <= a_next;
                b_reg <= b_next;
                c_reg <= c_next;
                d_reg <= d_next;
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mod_reg    <= modulus;
            signed_reg <= cmd.float_signed;
        end
        if (cmd.rnd_load)
        begin
            rnd_reg <= d_next;
        end
        if (cmd.accept)
        begin
            expo_reg <= UNIT_EXPO;
        end
        else if (cmd.expo_sub)
        begin
            expo_reg <= expo_reg - EXPO_STEP;
        end
        else if (cmd.expo_norm)
        begin
            expo_reg <= ({1'b0, nz} > expo_reg) ? '0 : expo_reg - {1'b0, nz};
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            dvd_reg <= cmd.div_sel_rnd ? rnd_reg : '1;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_diff[WORD_W] ? trial[WORD_W-1:0] : trial_diff[WORD_W-1:0];
            dvd_reg <= {dvd_reg[WORD_W-2:0], 1'b0};
        end
        if (cmd.cap_load)
        begin
            cap_reg <= ~rem_reg;
        end
        if (cmd.push)
        begin
            out_value_reg <= res_value;
        end
    end

endmodule

/* sv/jsfrg_ctrl.sv */
module jsfrg_ctrl
    import jsfrg_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [OP_W-1:0] opcode,
    input  dp_status_t      status,
    output logic            in_ready,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [3:0] {
        ST_SEED,
        ST_IDLE,
        ST_RAW,
        ST_CAPDIV,
        ST_DRAW,
        ST_CHECK,
        ST_REMDIV,
        ST_FDRAW,
        ST_FCHECK,
        ST_FEXTRA,
        ST_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    res_sel_t         sel_reg, sel_next;
    logic             accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.res_sel = sel_reg;
        unique case (state_reg)
            ST_SEED:
            begin
                cmd.round_en = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SEED_ROUNDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.accept       = 1'b1;
                    cmd.float_signed = (op_t'(opcode) == OP_SIGNED);
                    cnt_next         = '0;
                    unique case (op_t'(opcode))
                        OP_RESEED:
                        begin
                            cmd.load_seed = 1'b1;
                            state_next    = ST_SEED;
                        end
                        OP_RAW:
                        begin
                            state_next = ST_RAW;
                        end
                        OP_RANGED:
                        begin
                            if (status.mod_zero)
                            begin
                                state_next = ST_RAW;
                            end
                            else
                            begin
                                cmd.div_start = 1'b1;
                                state_next    = ST_CAPDIV;
                            end
                        end
                        OP_UNIT, OP_SIGNED:
                        begin
                            state_next = ST_FDRAW;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RAW:
            begin
                cmd.round_en = 1'b1;
                cmd.rnd_load = 1'b1;
                sel_next     = RES_RND;
                state_next   = ST_DONE;
            end
            ST_CAPDIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                cmd.round_en = 1'b1;
                cmd.rnd_load = 1'b1;
                cmd.cap_load = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.cap_ok)
                begin
                    cmd.div_start   = 1'b1;
                    cmd.div_sel_rnd = 1'b1;
                    cnt_next        = '0;
                    state_next      = ST_REMDIV;
                end
                else
                begin
                    state_next = ST_DRAW;
                end
            end
            ST_REMDIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    sel_next   = RES_REM;
                    state_next = ST_DONE;
                end
            end
            ST_FDRAW:
            begin
                cmd.round_en = 1'b1;
                cmd.rnd_load = 1'b1;
                state_next   = ST_FCHECK;
            end
            ST_FCHECK:
            begin
                sel_next = RES_FLOAT;
                if (status.loop_zero)
                begin
                    cmd.expo_sub = 1'b1;
                    state_next   = ST_FDRAW;
                end
                else
                begin
                    cmd.expo_norm = 1'b1;
                    state_next    = status.need_extra ? ST_FEXTRA : ST_DONE;
                end
            end
            ST_FEXTRA:
            begin
                cmd.round_en = 1'b1;
                cmd.rnd_load = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SEED;
            cnt_reg   <= '0;
            sel_reg   <= RES_RND;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

/* sv/jsf_random_generator_unit.sv */
// Four-word 32-bit small-fast random generator with a request stream in and a
// result stream out. Each input transaction carries an opcode: reseed, raw draw,
// ranged draw below a modulus, unit float in [0,1) or signed float in (-1,1).
// Reseed gives no output transaction; the other opcodes give exactly one, and
// opcodes five to seven are dropped without effect.
// One request is worked on at a time; s_axis_tready is high only while idle.
// All timing is set by the single-round datapath and a one-bit-per-cycle
// restoring remainder unit. A raw draw runs one round and loads the output
// register; a reseed keeps s_axis_tready low while it runs 20 rounds. A ranged
// draw with a nonzero modulus first finds the rejection cap with one remainder,
// draws again while the word is not below the cap, and then takes a second
// remainder; a zero modulus gives a raw draw. Float draws take longer the more
// all-zero words are drawn. After reset the block runs 20 rounds from a zero
// seed, with s_axis_tready low, before it is ready.
// A finished result sits in the output register until m_axis_tready takes it;
// while it waits, the block still accepts and works on the next request, and it
// holds that request's result back until the output register is free.
module jsf_random_generator_unit
    import jsfrg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // opcode[2:0], seed_value[34:3], modulus[66:35], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // value[31:0]
);

    ctrl_cmd_t         cmd;
    dp_status_t        status;
    logic [OP_W-1:0]   opcode;
    logic [WORD_W-1:0] seed_value;
    logic [WORD_W-1:0] modulus;

    assign opcode     = s_axis_tdata[2:0];
    assign seed_value = s_axis_tdata[34:3];
    assign modulus    = s_axis_tdata[66:35];

    jsfrg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .opcode   (opcode),
        .status   (status),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    jsfrg_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .seed_value (seed_value),
        .modulus    (modulus),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_value  (m_axis_tdata),
        .status     (status)
    );

endmodule

/* verif/tb_jsf_random_generator_unit.sv */
module tb_jsf_random_generator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import jsfrg_pkg::*;

    localparam logic [WORD_W-1:0] FRAC_MASK = 32'h007fffff;
    localparam logic [WORD_W-1:0] ALL_ONES = 32'hffffffff;
    localparam logic [WORD_W-1:0] HALF_RANGE = 32'h80000000;

    typedef struct {
        logic [OP_W-1:0]   opcode;
        logic [WORD_W-1:0] value;
    } draw_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    logic [WORD_W-1:0] word_a;
    logic [WORD_W-1:0] word_b;
    logic [WORD_W-1:0] word_c;
    logic [WORD_W-1:0] word_d;

    draw_result_t pending_draws[$];
    draw_result_t oldest_draw;
    int           error_count = 0;
    bit           idling_on = 1'b1;

    jsf_random_generator_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic [WORD_W-1:0] rotate_left(input logic [WORD_W-1:0] w,
                                                     input int unsigned k);
        return (w << k) | (w >> (WORD_W - k));
    endfunction

    function automatic logic [WORD_W-1:0] jsf_round();
        logic [WORD_W-1:0] e;
        e = word_a - rotate_left(word_b, ROT_B);
        word_a = word_b ^ rotate_left(word_c, ROT_C);
        word_b = word_c + word_d;
        word_c = word_d + e;
        word_d = e + word_a;
        return word_d;
    endfunction

    function automatic void reseed_words(input logic [WORD_W-1:0] seed);
        logic [WORD_W-1:0] discard;
        word_a = SEED_A;
        word_b = seed;
        word_c = seed;
        word_d = seed;
        for (int i = 0; i < SEED_ROUNDS; i++)
        begin
            discard = jsf_round();
        end
    endfunction

    function automatic int unsigned count_leading_zeros(input logic [WORD_W-1:0] w);
        int unsigned n;
        n = 0;
        while (n < WORD_W && !w[WORD_W - 1 - n])
        begin
            n++;
        end
        return n;
    endfunction

    function automatic logic [WORD_W-1:0] draw_float(input bit with_sign);
        int unsigned       expo;
        int unsigned       nz;
        logic [WORD_W-1:0] rnd;
        logic [WORD_W-1:0] bits;
        expo = UNIT_EXPO;
        rnd = jsf_round();
        while (rnd == '0 && expo > EXPO_STEP)
        begin
            expo -= EXPO_STEP;
            rnd = jsf_round();
        end
        nz = count_leading_zeros(rnd);
        expo = (nz > expo) ? 0 : expo - nz;
        if (nz > (with_sign ? EXTRA_SIGNED : EXTRA_UNIT))
        begin
            rnd = jsf_round();
        end
        bits = (expo << 23) | (rnd & FRAC_MASK);
        if (with_sign)
        begin
            bits[31] = rnd[23];
        end
        return bits;
    endfunction

    function automatic logic [WORD_W-1:0] draw_ranged(input logic [WORD_W-1:0] modulus);
        logic [WORD_W-1:0] cap;
        logic [WORD_W-1:0] v;
        if (modulus == '0)
        begin
            return jsf_round();
        end
        cap = ALL_ONES - (ALL_ONES % modulus);
        do
        begin
            v = jsf_round();
        end
        while (v >= cap);
        return v % modulus;
    endfunction

    function automatic void predict_draw(input logic [OP_W-1:0] opcode,
                                         input logic [WORD_W-1:0] seed,
                                         input logic [WORD_W-1:0] modulus,
                                         output bit produces,
                                         output logic [WORD_W-1:0] value);
        produces = 1'b1;
        value = '0;
        case (opcode)
            OP_RESEED:
            begin
                reseed_words(seed);
                produces = 1'b0;
            end
            OP_RAW:    value = jsf_round();
            OP_RANGED: value = draw_ranged(modulus);
            OP_UNIT:   value = draw_float(1'b0);
            OP_SIGNED: value = draw_float(1'b1);
            default:   produces = 1'b0;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] random_modulus();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return $urandom_range(1, 16);
            2:       return 32'd1 << $urandom_range(0, 31);
            3:       return HALF_RANGE + $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] random_seed();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ALL_ONES;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input logic [OP_W-1:0] opcode,
                                input logic [WORD_W-1:0] seed,
                                input logic [WORD_W-1:0] modulus);
        bit                produces;
        logic [WORD_W-1:0] value;
        if (idling_on && $urandom_range(0, 2) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, modulus, seed, opcode};
        do
        begin
            @(posedge clk);
        end
        while (s_axis_tready !== 1'b1);
        predict_draw(opcode, seed, modulus, produces, value);
        if (produces)
        begin
            pending_draws.push_back('{opcode, value});
        end
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (pending_draws.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_power_on_stream();
        send_request(OP_RAW, $urandom, $urandom);
        send_request(OP_RAW, $urandom, $urandom);
        wait_for_results();
    endtask

    task automatic test_reseed_values();
        send_request(OP_RESEED, '0, $urandom);
        send_request(OP_RAW, $urandom, $urandom);
        send_request(OP_RESEED, ALL_ONES, $urandom);
        send_request(OP_RAW, $urandom, $urandom);
        wait_for_results();
    endtask

    task automatic test_ranged_bounds();
        logic [WORD_W-1:0] bounds[8];
        bounds = '{32'd0, 32'd1, 32'd2, 32'd3, HALF_RANGE, HALF_RANGE + 32'd1,
                   ALL_ONES - 32'd1, ALL_ONES};
        foreach (bounds[i])
        begin
            send_request(OP_RANGED, $urandom, bounds[i]);
        end
        wait_for_results();
    endtask

    task automatic test_float_draws();
        repeat (3)
        begin
            send_request(OP_UNIT, $urandom, $urandom);
            send_request(OP_SIGNED, $urandom, $urandom);
        end
        wait_for_results();
    endtask

    task automatic test_ignored_opcodes();
        for (int code = OP_SIGNED + 1; code < (1 << OP_W); code++)
        begin
            send_request(code[OP_W-1:0], $urandom, $urandom);
        end
        send_request(OP_RAW, $urandom, $urandom);
        wait_for_results();
    endtask

    task automatic run_random_requests(input int count);
        int               sent;
        int unsigned      pick;
        logic [OP_W-1:0]  opcode;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                opcode = OP_RESEED;
            else if (pick < 28)
                opcode = OP_RAW;
            else if (pick < 58)
                opcode = OP_RANGED;
            else if (pick < 76)
                opcode = OP_UNIT;
            else if (pick < 95)
                opcode = OP_SIGNED;
            else
                opcode = OP_W'($urandom_range(OP_SIGNED + 1, (1 << OP_W) - 1));
            send_request(opcode, random_seed(), random_modulus());
            if (opcode <= OP_SIGNED)
            begin
                sent++;
            end
        end
        wait_for_results();
    endtask

    task automatic test_random_mix();
        run_random_requests(1200);
    endtask

    task automatic test_no_idle_stream();
        idling_on = 1'b0;
        run_random_requests(300);
    endtask

    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idling_on && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        begin
            if (pending_draws.size() == 0)
            begin
                $display("%0t: unexpected result transaction, expected none, actual %h",
                         $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                oldest_draw = pending_draws.pop_front();
                if (m_axis_tdata !== oldest_draw.value)
                begin
                    $display("%0t: value mismatch for opcode %0d, expected %h, actual %h",
                             $time, oldest_draw.opcode, oldest_draw.value, m_axis_tdata);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        reseed_words('0);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_power_on_stream();
        test_reseed_values();
        test_ranged_bounds();
        test_float_draws();
        test_ignored_opcodes();
        test_random_mix();
        test_no_idle_stream();

        repeat (100) @(posedge clk);
        if (pending_draws.size() != 0)
        begin
            $display("%0t: %0d result transactions never arrived, expected %h first",
                     $time, pending_draws.size(), pending_draws[0].value);
            error_count++;
        end
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* jsf_random_generator_unit.f */
sv/jsfrg_pkg.sv
sv/jsfrg_datapath.sv
sv/jsfrg_ctrl.sv
sv/jsf_random_generator_unit.sv
verif/tb_jsf_random_generator_unit.sv
